[src/bgst_pkg.sv]
// Package for the growable stack table: operation and status codes,
// field widths and the control bundle passed from the controller to the top.
// No dependencies.
`default_nettype none

package bgst_pkg;

  // Widths of the request and result fields.
  localparam int unsigned CountW = 11;
  localparam int unsigned DataW  = 32;

  // Register indexes of the configuration port.
  localparam logic CfgInitCap   = 1'b0;
  localparam logic CfgBlockSize = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [CountW-1:0] InitCapReset   = 11'd16;
  localparam logic [CountW-1:0] BlockSizeReset = 11'd16;

  typedef logic [CountW-1:0] count_t;
  typedef logic [DataW-1:0]  data_t;

  typedef enum logic [1:0] {
    MODE_APPEND = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_GET    = 2'd2,
    MODE_SET    = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_OVERFLOW    = 3'd1,
    ST_GROW_FAILED = 3'd2,
    ST_UNDERFLOW   = 3'd3,
    ST_WRONG_INDEX = 3'd4
  } status_e;

  // Decision for one request: what the memory does and the new counters.
  typedef struct packed {
    status_e status;
    logic    wr_en;
    logic    rd_en;
    count_t  count;
    count_t  cap;
  } bgst_ctl_t;

endpackage

`default_nettype wire

[src/bgst_in_if.sv]
// Request channel of the growable stack table: valid/ready and the request fields.
// Depends on bgst_pkg.
`default_nettype none

interface bgst_in_if;
  import bgst_pkg::*;

  logic   valid;
  logic   ready;
  mode_e  mode;
  data_t  item_value;
  count_t item_index;

  modport source (output valid, output mode, output item_value, output item_index,
                  input ready);
  modport sink   (input valid, input mode, input item_value, input item_index,
                  output ready);
endinterface

`default_nettype wire

[src/bgst_out_if.sv]
// Result channel of the growable stack table: valid/ready and the result fields.
// Depends on bgst_pkg.
`default_nettype none

interface bgst_out_if;
  import bgst_pkg::*;

  logic    valid;
  logic    ready;
  status_e status;
  data_t   read_value;
  count_t  item_count;
  count_t  capacity_now;

  modport source (output valid, output status, output read_value, output item_count,
                  output capacity_now, input ready);
  modport sink   (input valid, input status, input read_value, input item_count,
                  input capacity_now, output ready);
endinterface

`default_nettype wire

[src/bgst_ram.sv]
// Single-port word memory of the growable stack table, registered read data.
// No package dependencies.
`default_nettype none

module bgst_ram #(
  parameter int unsigned DEPTH  = 1024,
  parameter int unsigned WIDTH  = 32,
  parameter int unsigned AddrW  = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             wr_en_i,
  input  wire logic             rd_en_i,
  input  wire logic [AddrW-1:0] addr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Writes the addressed entry on wr_en_i and, on rd_en_i, registers its old contents.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[src/bgst_ctrl.sv]
// Controller of the growable stack table: configuration registers, count and
// capacity, and the per-request decision. Depends on bgst_pkg.
`default_nettype none

module bgst_ctrl import bgst_pkg::*; #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AddrW = $clog2(DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic              cfg_idx_i,
  input  wire count_t            cfg_data_i,
  input  wire logic              advance_i,
  input  wire mode_e             mode_i,
  input  wire count_t            index_i,
  output bgst_ctl_t              ctl_o,
  output logic       [AddrW-1:0] addr_o
);

  // Arithmetic width: holds DEPTH, a sum of two counters and twice a block.
  localparam int unsigned SumW =
      ($clog2(DEPTH + 1) + 1 > CountW + 1) ? $clog2(DEPTH + 1) + 1 : CountW + 1;
  localparam logic [SumW-1:0] DepthW = SumW'(DEPTH);
  localparam logic [SumW-1:0] ResetCapW =
      (SumW'(InitCapReset) > DepthW) ? DepthW : SumW'(InitCapReset);

  count_t init_cap_q, block_q, count_q, cap_q;
  count_t count_d, cap_d;

  logic [SumW-1:0] cnt_w, cap_w, blk_w, init_w, idx_w;
  logic [SumW-1:0] floor_w, cfg_w, cfg_clamp_w;
  logic [SumW-1:0] cnt_n_w, cap_n_w, addr_w;

  always_comb begin
    cnt_w   = SumW'(count_q);
    cap_w   = SumW'(cap_q);
    blk_w   = SumW'(block_q);
    init_w  = SumW'(init_cap_q);
    idx_w   = SumW'(index_i);
    floor_w = (init_w > DepthW) ? DepthW : init_w;
    cfg_w   = SumW'(cfg_data_i);
    cfg_clamp_w = (cfg_w > DepthW) ? DepthW : cfg_w;
  end

  // Decide status, memory access and new counters for the held request.
  always_comb begin
    ctl_o.status = ST_OK;
    ctl_o.wr_en  = 1'b0;
    ctl_o.rd_en  = 1'b0;
    cnt_n_w      = cnt_w;
    cap_n_w      = cap_w;
    addr_w       = cnt_w;
    unique case (mode_i)
      MODE_APPEND: begin
        if (cnt_w < cap_w) begin
          ctl_o.wr_en = 1'b1;
          cnt_n_w     = cnt_w + 1'b1;
        end else if (block_q == '0) begin
          ctl_o.status = ST_OVERFLOW;
        end else if (cap_w + blk_w > DepthW) begin
          ctl_o.status = ST_GROW_FAILED;
        end else begin
          cap_n_w = cap_w + blk_w;
          if (cnt_w < DepthW) begin
            ctl_o.wr_en = 1'b1;
            cnt_n_w     = cnt_w + 1'b1;
          end
        end
      end
      MODE_REMOVE: begin
        if (count_q == '0) begin
          ctl_o.status = ST_UNDERFLOW;
        end else begin
          cnt_n_w     = cnt_w - 1'b1;
          addr_w      = cnt_w - 1'b1;
          ctl_o.rd_en = 1'b1;
          // Give back one block when enough room is free above the floor.
          if (cap_w >= blk_w && cap_w - blk_w >= floor_w &&
              cap_w - (cnt_w - 1'b1) >= (blk_w << 1)) begin
            cap_n_w = cap_w - blk_w;
          end
        end
      end
      MODE_GET, MODE_SET: begin
        addr_w = idx_w - 1'b1;
        if (index_i == '0 || idx_w > cnt_w || idx_w > DepthW) begin
          ctl_o.status = ST_WRONG_INDEX;
        end else if (mode_i == MODE_GET) begin
          ctl_o.rd_en = 1'b1;
        end else begin
          ctl_o.wr_en = 1'b1;
        end
      end
      default: begin
        ctl_o.status = ST_OK;
      end
    endcase
    ctl_o.count = cnt_n_w[CountW-1:0];
    ctl_o.cap   = cap_n_w[CountW-1:0];
    addr_o      = addr_w[AddrW-1:0];
  end

  // Writes of initial_capacity re-create the table; with no configuration write, take the decision.
  always_comb begin
    count_d = count_q;
    cap_d   = cap_q;
    if (cfg_we_i) begin
      if (cfg_idx_i == CfgInitCap) begin
        count_d = '0;
        cap_d   = cfg_clamp_w[CountW-1:0];
      end
    end else if (advance_i) begin
      count_d = ctl_o.count;
      cap_d   = ctl_o.cap;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_cap_q <= InitCapReset;
      block_q    <= BlockSizeReset;
      count_q    <= '0;
      cap_q      <= ResetCapW[CountW-1:0];
    end else begin
      count_q <= count_d;
      cap_q   <= cap_d;
      if (cfg_we_i && cfg_idx_i == CfgInitCap) begin
        init_cap_q <= cfg_data_i;
      end
      if (cfg_we_i && cfg_idx_i == CfgBlockSize) begin
        block_q <= cfg_data_i;
      end
    end
  end

endmodule

`default_nettype wire

[src/block_growable_stack_table_top.sv]
// Top level of the growable stack table: request register, controller,
// word memory and result register. Depends on bgst_pkg, bgst_in_if,
// bgst_out_if, bgst_ctrl and bgst_ram.
`default_nettype none

// A stack of words with 1-based random access (append, remove, get, set) whose
// capacity grows and shrinks in steps of block_size. The block takes one request
// per clock cycle while the result register is not stalled. A taken request is held
// in the request register, where count and capacity are decided and the single-port
// memory is written or read; its result then moves to the result register. Each
// request makes at most one memory access, so the one memory port sets the rate of
// one request per cycle. Writing initial_capacity empties the table; configuration
// may only be written while no request is in flight.
module block_growable_stack_table_top import bgst_pkg::*; #(
  parameter int unsigned DEPTH      = 1024,
  parameter int unsigned WORD_WIDTH = 32
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   cfg_we_i,
  input  wire logic   cfg_idx_i,
  input  wire count_t cfg_data_i,
  bgst_in_if.sink     in_i,
  bgst_out_if.source  out_o
);

  localparam int unsigned AddrW  = $clog2(DEPTH);
  localparam int unsigned StoreW = (WORD_WIDTH < DataW) ? WORD_WIDTH : DataW;

  // Request register.
  logic   req_valid_q;
  mode_e  req_mode_q;
  data_t  req_value_q;
  count_t req_index_q;

  // Result register.
  logic    rsp_valid_q;
  status_e rsp_status_q;
  logic    rsp_rd_q;
  count_t  rsp_count_q;
  count_t  rsp_cap_q;

  logic              advance;
  bgst_ctl_t         ctl;
  logic [AddrW-1:0]  mem_addr;
  logic [StoreW-1:0] mem_rdata;

  assign advance    = req_valid_q && (!rsp_valid_q || out_o.ready);
  assign in_i.ready = !req_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      req_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      req_mode_q  <= in_i.mode;
      req_value_q <= in_i.item_value;
      req_index_q <= in_i.item_index;
    end
  end

  bgst_ctrl #(
    .DEPTH (DEPTH),
    .AddrW (AddrW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .advance_i  (advance),
    .mode_i     (req_mode_q),
    .index_i    (req_index_q),
    .ctl_o      (ctl),
    .addr_o     (mem_addr)
  );

  bgst_ram #(
    .DEPTH (DEPTH),
    .WIDTH (StoreW),
    .AddrW (AddrW)
  ) u_ram (
    .clk_i   (clk_i),
    .wr_en_i (advance && ctl.wr_en),
    .rd_en_i (advance && ctl.rd_en),
    .addr_i  (mem_addr),
    .wdata_i (req_value_q[StoreW-1:0]),
    .rdata_o (mem_rdata)
  );

  // Result register; the memory's read register holds the read word alongside.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (!rsp_valid_q || out_o.ready) begin
      rsp_valid_q <= req_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      rsp_status_q <= ctl.status;
      rsp_rd_q     <= ctl.rd_en;
      rsp_count_q  <= ctl.count;
      rsp_cap_q    <= ctl.cap;
    end
  end

  assign out_o.valid        = rsp_valid_q;
  assign out_o.status       = rsp_status_q;
  assign out_o.read_value   = rsp_rd_q ? DataW'(mem_rdata) : '0;
  assign out_o.item_count   = rsp_count_q;
  assign out_o.capacity_now = rsp_cap_q;

endmodule

`default_nettype wire

[src/bgst_checker.sv]
// Port-level checks of the growable stack table, bound to the top level.
// Depends on bgst_pkg and bgst_out_if.
`default_nettype none

module bgst_checker import bgst_pkg::*; #(
  parameter int unsigned DEPTH = 1024
) (
  input wire logic    clk_i,
  input wire logic    rst_ni,
  bgst_out_if.source  out_o
);

  // The count never exceeds the capacity it is reported with.
  a_count_le_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.item_count <= out_o.capacity_now)
    else $error("item count above capacity");

  // The capacity never exceeds the memory depth.
  a_cap_le_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> 32'(out_o.capacity_now) <= DEPTH)
    else $error("capacity above memory depth");

  // A failed request returns no word.
  a_fail_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.status != ST_OK) |-> out_o.read_value == '0)
    else $error("read value on failed request");

  // A stalled result holds.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |=>
      (out_o.valid && $stable(out_o.status) && $stable(out_o.read_value) &&
       $stable(out_o.item_count) && $stable(out_o.capacity_now)))
    else $error("stalled result changed");

endmodule

bind block_growable_stack_table_top bgst_checker #(.DEPTH(DEPTH)) u_bgst_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .out_o  (out_o)
);

`default_nettype wire
